>>> sv/tbdq_pkg.sv
// Shared constants, types and tables for the temporal Bayer dither quantiser.
package tbdq_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int VALUE_W     = 18;
   localparam int COORD_W     = 16;
   localparam int FRAME_W     = 32;
   localparam int P_W         = 16;
   localparam int Q_W         = 17;
   localparam int DV_W        = 17;
   localparam int BYTE_W      = 8;
   localparam int CELL_W      = 4;

   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // remainder divider: restoring, DIV_STEPS quotient bits per stage
   localparam int DIV_W       = 36;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = DIV_W / DIV_STEPS;
   localparam int TAG_W       = 25;

   localparam int RQ_W        = P_W + Q_W;
   localparam int C_W         = 7;
   localparam int S_W         = 25;
   localparam int OFS_W       = S_W - 4;
   localparam int SUM_W       = OFS_W + 1;
   localparam int ROUND_W     = DV_W + BYTE_W + 1;

   localparam logic [SUM_W-1:0]   ONE_Q  = SUM_W'(1) << FRAC_BITS;
   localparam logic [ROUND_W-1:0] HALF_Q = ROUND_W'(1) << (FRAC_BITS - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PERIOD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DITHER_QUANTUM = 2'd1;

   localparam logic [P_W-1:0] PERIOD_RESET  = 16'd8;
   localparam logic [Q_W-1:0] QUANTUM_RESET = 17'd257;

   // 4x4 Bayer cell, index is {y[1:0], x[1:0]}
   function automatic logic [CELL_W-1:0] bayer_cell(input logic [3:0] idx);
      logic [CELL_W-1:0] rank;
      case (idx)
         4'd0:  rank = 4'd0;
         4'd1:  rank = 4'd8;
         4'd2:  rank = 4'd2;
         4'd3:  rank = 4'd10;
         4'd4:  rank = 4'd12;
         4'd5:  rank = 4'd4;
         4'd6:  rank = 4'd14;
         4'd7:  rank = 4'd6;
         4'd8:  rank = 4'd3;
         4'd9:  rank = 4'd11;
         4'd10: rank = 4'd1;
         4'd11: rank = 4'd9;
         4'd12: rank = 4'd15;
         4'd13: rank = 4'd7;
         4'd14: rank = 4'd13;
         4'd15: rank = 4'd5;
         default: rank = 4'd0;
      endcase
      return rank;
   endfunction

endpackage

>>> sv/temporal_bayer_dither_quantiser.sv
// Top level of the temporal Bayer ordered-dither quantiser pipeline.
//
//  channel | direction | word contents (lowest bits first)
//  --------+-----------+--------------------------------------------------------
//  req_    | in        | value_in[17:0], pixel_x[15:0], pixel_y[15:0], frame_count[31:0]
//  rsp_    | out       | dithered_value[16:0], quantised_byte[7:0]
//  csr_    | in        | index 0 frame_period, index 1 dither_quantum
//
//  One word enters per cycle and one result leaves per cycle while the output is
//  not stalled; the pipe runs through the two 4-bit-per-stage remainder dividers.
//  Reset clears all valid bits and loads period 8 and quantum 257.
//  A stalled result holds the whole pipe unless the stage in front of the
//  output is empty, in which case the earlier stages still advance.
//  CSR writes are always accepted; indexes beyond the list are dropped.
module temporal_bayer_dither_quantiser (
   input  logic                                clock,
   input  logic                                reset,
   // value_in, pixel_x, pixel_y, frame_count, zero padded
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tbdq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // dithered_value, quantised_byte, zero padded
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbdq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbdq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbdq_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tbdq_pkg::*;

   // configuration; period is stored already mapped so zero reads as one
   logic [P_W-1:0] period_ff;
   logic [Q_W-1:0] quantum_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_PERIOD: begin
               period_ff <= (csr_data[P_W-1:0] == '0) ? P_W'(1) : csr_data[P_W-1:0];
            end
            CSR_DITHER_QUANTUM: begin
               quantum_ff <= csr_data[Q_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // advance unless the output is full and stalled and stage D holds a word
   logic en;
   logic rsp_valid_ff;
   logic d_valid_ff;
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign en         = out_free || !d_valid_ff;
   assign req_tready = en;

   // stage 0: capture the word and look up the Bayer cell
   logic                 s0_valid_ff;
   logic [VALUE_W-1:0]   s0_value_ff;
   logic [CELL_W-1:0]    s0_cell_ff;
   logic [FRAME_W-1:0]   s0_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_value_ff <= req_tdata[VALUE_W-1:0];
         s0_cell_ff  <= bayer_cell({req_tdata[VALUE_W+COORD_W+1:VALUE_W+COORD_W],
                                    req_tdata[VALUE_W+1:VALUE_W]});
         s0_frame_ff <= req_tdata[VALUE_W+2*COORD_W+FRAME_W-1:VALUE_W+2*COORD_W];
      end
   end

   // divider 1: r = frame mod period
   logic               dv1_valid;
   logic [DIV_W-1:0]   dv1_quotient;
   logic [P_W-1:0]     dv1_rem;
   logic [TAG_W-1:0]   dv1_tag;

   tbdq_divider u_frame_mod (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (s0_valid_ff),
      .in_dividend   (DIV_W'(s0_frame_ff)),
      .in_divisor    (period_ff),
      .in_tag        ({3'b000, s0_cell_ff, s0_value_ff}),
      .out_valid     (dv1_valid),
      .out_quotient  (dv1_quotient),
      .out_remainder (dv1_rem),
      .out_tag       (dv1_tag)
   );

   // stage A: wrap test for the threshold sum, and r * q for the phase offset
   logic [CELL_W-1:0]    a_cell;
   logic [P_W+6-1:0]     a_mpre;
   logic                 a_wrap;
   logic                 a_valid_ff;
   logic [VALUE_W-1:0]   a_value_ff;
   logic [C_W-1:0]       a_c_ff;
   logic [C_W-1:0]       a_c_in;
   logic [RQ_W-1:0]      a_rq_ff;

   always_comb begin
      a_cell = dv1_tag[VALUE_W+CELL_W-1:VALUE_W];
      a_mpre = (P_W+6)'({a_cell, 1'b1}) * (P_W+6)'(period_ff)
             + (P_W+6)'({dv1_rem, 5'b00000});
      a_wrap = a_mpre >= (P_W+6)'({period_ff, 5'b00000});
      // c = 2b - 15, less 32 on wrap
      a_c_in = C_W'({a_cell, 1'b0}) - C_W'(15) - (a_wrap ? C_W'(32) : C_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= dv1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_value_ff <= dv1_tag[VALUE_W-1:0];
         a_c_ff     <= a_c_in;
         a_rq_ff    <= RQ_W'(dv1_rem) * RQ_W'(quantum_ff);
      end
   end

   // divider 2: Q1, R1 = (r * q) divmod period
   logic               dv2_valid;
   logic [DIV_W-1:0]   dv2_quotient;
   logic [P_W-1:0]     dv2_rem;
   logic [TAG_W-1:0]   dv2_tag;

   tbdq_divider u_phase_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (a_valid_ff),
      .in_dividend   (DIV_W'(a_rq_ff)),
      .in_divisor    (period_ff),
      .in_tag        ({a_c_ff, a_value_ff}),
      .out_valid     (dv2_valid),
      .out_quotient  (dv2_quotient),
      .out_remainder (dv2_rem),
      .out_tag       (dv2_tag)
   );

   // stage B: S = c*q + 16 + 32*Q1, two's complement in S_W bits
   logic [S_W-1:0]       b_c_ext;
   logic [S_W-1:0]       b_s_in;
   logic                 b_valid_ff;
   logic [VALUE_W-1:0]   b_value_ff;
   logic [S_W-1:0]       b_s_ff;
   logic [P_W-1:0]       b_r1_ff;

   always_comb begin
      b_c_ext = {{(S_W-C_W){dv2_tag[VALUE_W+C_W-1]}}, dv2_tag[VALUE_W+C_W-1:VALUE_W]};
      b_s_in  = S_W'(b_c_ext * S_W'(quantum_ff)) + S_W'(16)
              + S_W'({dv2_quotient[Q_W-1:0], 5'b00000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= dv2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_value_ff <= dv2_tag[VALUE_W-1:0];
         b_s_ff     <= b_s_in;
         b_r1_ff    <= dv2_rem;
      end
   end

   // stage C: offset = floor(S/32) plus one when p*(S mod 32) + 32*R1 reaches 32p
   logic [P_W+6-1:0]     c_lhs;
   logic                 c_carry;
   logic                 c_valid_ff;
   logic [VALUE_W-1:0]   c_value_ff;
   logic [OFS_W-1:0]     c_offset_ff;

   always_comb begin
      c_lhs   = (P_W+6)'(b_s_ff[4:0]) * (P_W+6)'(period_ff)
              + (P_W+6)'({b_r1_ff, 5'b00000});
      c_carry = c_lhs >= (P_W+6)'({period_ff, 5'b00000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_value_ff  <= b_value_ff;
         c_offset_ff <= {b_s_ff[S_W-1], b_s_ff[S_W-1:5]} + OFS_W'(c_carry);
      end
   end

   // stage D: add offset, clamp to [0, 1.0]
   logic [SUM_W-1:0]     d_sum;
   logic [DV_W-1:0]      d_dv_in;
   logic [DV_W-1:0]      d_dv_ff;

   always_comb begin
      d_sum = {{(SUM_W-VALUE_W){c_value_ff[VALUE_W-1]}}, c_value_ff}
            + {c_offset_ff[OFS_W-1], c_offset_ff};
      if (d_sum[SUM_W-1]) begin
         d_dv_in = '0;
      end else if (d_sum > ONE_Q) begin
         d_dv_in = DV_W'(ONE_Q);
      end else begin
         d_dv_in = d_sum[DV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_dv_ff <= d_dv_in;
      end
   end

   // stage E: round to a byte and load the output register
   logic [ROUND_W-1:0]   e_prod;
   logic [BYTE_W:0]      e_wide;
   logic [BYTE_W-1:0]    e_byte;
   logic [DV_W-1:0]      rsp_dv_ff;
   logic [BYTE_W-1:0]    rsp_byte_ff;

   always_comb begin
      e_prod = {d_dv_ff, {BYTE_W{1'b0}}} - ROUND_W'(d_dv_ff) + HALF_Q;
      e_wide = e_prod[FRAC_BITS+BYTE_W:FRAC_BITS];
      e_byte = e_wide[BYTE_W] ? {BYTE_W{1'b1}} : e_wide[BYTE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_dv_ff   <= d_dv_ff;
         rsp_byte_ff <= e_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-DV_W-BYTE_W){1'b0}}, rsp_byte_ff, rsp_dv_ff};

endmodule

>>> sv/tbdq_divider.sv
// Pipelined restoring divider: quotient and remainder with a tag carried alongside.
module tbdq_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [tbdq_pkg::DIV_W-1:0]  in_dividend,
   input  logic [tbdq_pkg::P_W-1:0]    in_divisor,
   input  logic [tbdq_pkg::TAG_W-1:0]  in_tag,
   output logic                        out_valid,
   output logic [tbdq_pkg::DIV_W-1:0]  out_quotient,
   output logic [tbdq_pkg::P_W-1:0]    out_remainder,
   output logic [tbdq_pkg::TAG_W-1:0]  out_tag
);
   import tbdq_pkg::*;

   typedef struct packed {
      logic [P_W-1:0]   rem;
      logic [DIV_W-1:0] dq;
      logic [TAG_W-1:0] tag;
   } div_word_type;

   function automatic div_word_type div_steps(input div_word_type w, input logic [P_W-1:0] d);
      div_word_type r;
      logic [P_W:0] trial;
      r = w;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial = {r.rem, r.dq[DIV_W-1]};
         r.dq  = {r.dq[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            r.rem   = P_W'(trial - {1'b0, d});
            r.dq[0] = 1'b1;
         end else begin
            r.rem = trial[P_W-1:0];
         end
      end
      return r;
   endfunction

   div_word_type              start_word;
   div_word_type              word_ff [DIV_STAGES];
   div_word_type              word_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]     valid_ff;
   logic [DIV_STAGES-1:0]     valid_in;

   always_comb begin
      start_word.rem = '0;
      start_word.dq  = in_dividend;
      start_word.tag = in_tag;
      word_in[0]     = div_steps(start_word, in_divisor);
      valid_in[0]    = in_valid;
      for (int i = 1; i < DIV_STAGES; i++) begin
         word_in[i]  = div_steps(word_ff[i-1], in_divisor);
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid     = valid_ff[DIV_STAGES-1];
   assign out_quotient  = word_ff[DIV_STAGES-1].dq;
   assign out_remainder = word_ff[DIV_STAGES-1].rem;
   assign out_tag       = word_ff[DIV_STAGES-1].tag;

endmodule

>>> sv/tbdq_checker.sv
// Port-level assertions for the dither quantiser, bound to the top level.
module tbdq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tbdq_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tbdq_pkg::*;

   logic [ROUND_W-1:0] chk_prod;
   logic [BYTE_W-1:0]  chk_byte;

   always_comb begin
      chk_prod = ROUND_W'(rsp_tdata[DV_W-1:0]) * ROUND_W'(255) + HALF_Q;
      chk_byte = chk_prod[FRAC_BITS+BYTE_W-1:FRAC_BITS];
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_dv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DV_W-1:0] <= DV_W'(ONE_Q))
      else $error("dithered value above full scale");

   a_byte_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DV_W+BYTE_W-1:DV_W] == chk_byte)
      else $error("quantised byte disagrees with dithered value");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind temporal_bayer_dither_quantiser tbdq_checker u_tbdq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/dither_result_checker.sv
// Scoreboard for the dither quantiser: tracks the CSRs, predicts each pixel and checks results.
module dither_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [tbdq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tbdq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [tbdq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbdq_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatch_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import tbdq_pkg::*;

   localparam longint FULL_SCALE = longint'(1) << FRAC_BITS;

   // dithered level in the low bits, matching the rsp word layout
   typedef struct packed {
      logic [BYTE_W-1:0] code;
      logic [DV_W-1:0]   level;
   } pixel_out_type;

   logic [P_W-1:0] period_q;
   logic [Q_W-1:0] quantum_q;
   pixel_out_type  expected_pixels[$];
   int             mismatches;

   // Bayer rank from the bit-reversed interleave of (x^y, y)
   function automatic logic [CELL_W-1:0] threshold_rank(input logic [1:0] x, input logic [1:0] y);
      return {x[0] ^ y[0], y[0], x[1] ^ y[1], y[1]};
   endfunction

   function automatic pixel_out_type predict_dither(input logic signed [VALUE_W-1:0] value,
                                                    input logic [1:0] x, input logic [1:0] y,
                                                    input logic [FRAME_W-1:0] frame);
      longint        per, rot, span, pos, scaled, ofs, level;
      pixel_out_type res;
      per    = (period_q == '0) ? 1 : longint'(period_q);
      rot    = (frame == '0) ? 0 : longint'(frame) % per;
      span   = 32 * per;
      pos    = ((2 * longint'(threshold_rank(x, y)) + 1) * per + 32 * rot) % span;
      // bias by half a step, then floor, so ties round up
      scaled = (pos - 16 * per) * longint'(quantum_q) + 16 * per;
      ofs    = scaled / span;
      if (scaled < 0 && (scaled % span) != 0)
         ofs = ofs - 1;
      level = longint'(value) + ofs;
      if (level < 0)
         level = 0;
      if (level > FULL_SCALE)
         level = FULL_SCALE;
      res.level = DV_W'(level);
      res.code  = BYTE_W'((level * 255 + FULL_SCALE / 2) >> FRAC_BITS);
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_out_type seen, want;
      if (reset) begin
         period_q  = PERIOD_RESET;
         quantum_q = QUANTUM_RESET;
         expected_pixels.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_PERIOD:   period_q  = csr_data[P_W-1:0];
               CSR_DITHER_QUANTUM: quantum_q = csr_data[Q_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(predict_dither(
               req_tdata[VALUE_W-1:0],
               req_tdata[VALUE_W +: 2],
               req_tdata[VALUE_W+COORD_W +: 2],
               req_tdata[VALUE_W+2*COORD_W +: FRAME_W]));
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[DV_W+BYTE_W-1:0];
            if (expected_pixels.size() == 0) begin
               $error("rsp word with nothing expected: dithered_value %0d quantised_byte %0d",
                      seen.level, seen.code);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (seen.level !== want.level) begin
                  $error("dithered_value: expected %0d, got %0d", want.level, seen.level);
                  mismatches++;
               end
               if (seen.code !== want.code) begin
                  $error("quantised_byte: expected %0d, got %0d", want.code, seen.code);
                  mismatches++;
               end
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_pixels.size();
   end

endmodule

>>> bench/tb_temporal_bayer_dither_quantiser.sv
// Stimulus, flow control and verdict for the temporal Bayer dither quantiser.
module tb_temporal_bayer_dither_quantiser;
   timeunit 1ns;
   timeprecision 1ps;

   import tbdq_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 7;
   // two dividers of DIV_STAGES each plus the surrounding stages
   localparam int PIPE_LATENCY    = 2 * DIV_STAGES + 6;
   localparam int HOLD_OFF_CYCLES = 300;
   // longest quiet stretch of a correct run is the hold-off; allow several times that
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTING_COUNT   = 8;
   localparam int WORDS_PER_SETTING = 200;

   // indexes past the register list; the block must drop writes to them
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   localparam int VALUE_EXTREMES [7] = '{-131072, 131071, 0, 1, 65535, 65536, -1};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // value_in, pixel_x, pixel_y, frame_count from bit 0 up, zero padded
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // dithered_value, quantised_byte from bit 0 up, zero padded
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int mismatch_total;
   int waiting_words;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int words_sent   = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;
   bit hold_trigger = 1'b0;
   bit hold_done    = 1'b0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   temporal_bayer_dither_quantiser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dither_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_total),
      .pending_count  (waiting_words)
   );

   // Result side: drop tready at random, or hold it low for one long stretch on request
   // so the pipe fills and pushes back on the request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_trigger && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_OFF_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: end the run once nothing has moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d words outstanding", quiet_cycles,
                  waiting_words);
         $display("tb_temporal_bayer_dither_quantiser: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_pixel(input logic [VALUE_W-1:0] value,
                                                        input logic [COORD_W-1:0] x,
                                                        input logic [COORD_W-1:0] y,
                                                        input logic [FRAME_W-1:0] frame);
      return REQ_DATA_W'({frame, y, x, value});
   endfunction

   // Mostly values around the 0..1 band where the dither offset shows, the rest
   // anywhere in range; coordinates fully random so every bit toggles.
   function automatic logic [REQ_DATA_W-1:0] random_pixel();
      logic [VALUE_W-1:0] value;
      logic [FRAME_W-1:0] frame;
      case ($urandom_range(9))
         0, 1:    value = VALUE_W'($urandom);
         2:       value = VALUE_W'(VALUE_EXTREMES[$urandom_range(6)]);
         default: value = VALUE_W'(int'($urandom_range(131072)) - 32768);
      endcase
      case ($urandom_range(4))
         0:       frame = '0;
         1, 2:    frame = $urandom;
         default: frame = FRAME_W'($urandom_range(255));
      endcase
      return pack_pixel(value, COORD_W'($urandom), COORD_W'($urandom), frame);
   endfunction

   // Offer one word, idling first at the sender's rate; leave tvalid high afterwards
   // so back-to-back words never toggle it within a step.
   task automatic offer_pixel(input logic [REQ_DATA_W-1:0] word);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Drop tvalid and wait until every expected result has come back.
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (waiting_words != 0);
   endtask

   // Write both registers back to back, optionally followed by writes the block must drop.
   task automatic program_csr(input logic [CSR_DATA_W-1:0] period_word,
                              input logic [CSR_DATA_W-1:0] quantum_word,
                              input bit                    poke_unmapped);
      logic [CSR_INDEX_W-1:0] idx[$];
      logic [CSR_DATA_W-1:0]  val[$];
      idx.push_back(CSR_FRAME_PERIOD);
      val.push_back(period_word);
      idx.push_back(CSR_DITHER_QUANTUM);
      val.push_back(quantum_word);
      if (poke_unmapped) begin
         idx.push_back(CSR_UNMAPPED_LO);
         val.push_back('1);
         idx.push_back(CSR_UNMAPPED_HI);
         val.push_back('0);
      end
      csr_valid <= 1'b1;
      foreach (idx[i]) begin
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] period_words  [SETTING_COUNT];
      logic [CSR_DATA_W-1:0] quantum_words [SETTING_COUNT];

      // Register settings: no dither, widest period with full-scale quantum, zero period
      // with a quantum past full scale, a period word with bit 16 set (the bit is ignored),
      // then random ones, a return to the reset values and one last random setting.
      period_words[0] = 17'd1;       quantum_words[0] = 17'd0;
      period_words[1] = 17'd65535;   quantum_words[1] = 17'd65536;
      period_words[2] = 17'd0;       quantum_words[2] = 17'd131071;
      period_words[3] = 17'h1_0003;  quantum_words[3] = 17'd4096;
      period_words[4] = CSR_DATA_W'($urandom_range(2, 64));
      quantum_words[4] = CSR_DATA_W'($urandom_range(65536));
      period_words[5] = CSR_DATA_W'($urandom);
      quantum_words[5] = CSR_DATA_W'($urandom);
      period_words[6] = CSR_DATA_W'(PERIOD_RESET);
      quantum_words[6] = CSR_DATA_W'(QUANTUM_RESET);
      period_words[7] = CSR_DATA_W'($urandom_range(1, 16));
      quantum_words[7] = CSR_DATA_W'($urandom_range(1024, 65536));

      // hold reset, then release it on an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // first idling mix: sender lazy, receiver lazier
      tx_idle_pct = 35;
      rx_idle_pct <= 57;

      // Directed words under the reset registers: every Bayer cell (with high coordinate
      // bits set on some), frame zero and a frame that is a whole number of periods.
      for (int c = 0; c < 16; c++)
         offer_pixel(pack_pixel(VALUE_W'(32768), COORD_W'((c % 4) + 4 * c),
                                COORD_W'((c / 4) + 256 * c), FRAME_W'(c)));
      // value extremes, largest coordinates and frame
      offer_pixel(pack_pixel(VALUE_W'(-131072), 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      offer_pixel(pack_pixel(VALUE_W'(131071), 16'hFFFC, 16'hFFFE, 32'd1));
      offer_pixel(pack_pixel(VALUE_W'(0), 16'd0, 16'd0, 32'd0));
      offer_pixel(pack_pixel(VALUE_W'(65536), 16'd3, 16'd3, 32'd7));
      offer_pixel(pack_pixel(VALUE_W'(65535), 16'd1, 16'd2, 32'd8));
      offer_pixel(pack_pixel(VALUE_W'(1), 16'd2, 16'd1, 32'd0));

      for (int s = 0; s < SETTING_COUNT; s++) begin
         drain_pipe();
         program_csr(period_words[s], quantum_words[s], s == 3);
         // advance the idling mix: swapped at the second third, none at the last
         if (s == 3) begin
            tx_idle_pct = 57;
            rx_idle_pct <= 35;
         end else if (s == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
            // stall the output while the sender keeps offering
            hold_trigger <= 1'b1;
         end
         for (int n = 0; n < WORDS_PER_SETTING; n++)
            offer_pixel(random_pixel());
      end

      drain_pipe();
      // catch any stray result the block might still emit
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("sent %0d pixel words over %0d register settings plus the reset values,",
               words_sent, SETTING_COUNT);
      $display("with both sides idling and a %0d-cycle output stall; %0d mismatches",
               HOLD_OFF_CYCLES, mismatch_total);
      if (mismatch_total == 0 && waiting_words == 0 && hold_done)
         $display("tb_temporal_bayer_dither_quantiser: PASS");
      else
         $display("tb_temporal_bayer_dither_quantiser: FAIL");
      $finish;
   end

endmodule
